// ===== rtl/core/wvm_pkg.sv =====
// shared types, codes and constants of the wavetable voice mixer
package wvm_pkg;

    // fixed table count and default sizes
    localparam int NUM_TABLES        = 12;
    localparam int DEF_NUM_VOICES    = 8;
    localparam int DEF_MAX_TABLE_LEN = 1024;
    localparam logic [15:0] OFFSET_RESET = 16'h8000;

    // request kinds
    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_START  = 2'd1,
        ACT_WRITE  = 2'd2,
        ACT_LENGTH = 2'd3
    } t_action;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_VOICE = 2'd1,
        STAT_STEP     = 2'd2,
        STAT_BAD_ADDR = 2'd3
    } t_status;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_FLUSH,
        ST_FINISH
    } t_state;

    // input request payload
    typedef struct packed {
        t_action            action;
        logic [15:0]        cur_measure;
        logic [7:0]         cur_location;
        logic [3:0]         note_code;
        logic [2:0]         pitch;
        logic [15:0]        end_measure;
        logic [7:0]         end_location;
        logic [9:0]         table_address;
        logic signed [15:0] sample_value;
        logic [10:0]        table_length;
    } t_in_item;

    // result payload
    typedef struct packed {
        logic signed [19:0] mixed_sample;
        t_status            status;
        logic [2:0]         voice_index;
        logic [3:0]         active_voices;
    } t_out_item;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic scan;
        logic finish;
    } t_dp_cmd;

endpackage

// ===== rtl/core/wvm_ctrl.sv =====
// controller state machine: sequences requests and the voice scan of a tick
module wvm_ctrl
    import wvm_pkg::*;
#(
    parameter int NUM_VOICES = DEF_NUM_VOICES,
    localparam int VIDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_action           i_action,
    output logic              o_busy,
    output logic              o_done,
    output t_dp_cmd           o_cmd,
    output logic [VIDX_W-1:0] o_voice
);

    localparam logic [VIDX_W-1:0] LAST_VOICE = VIDX_W'(NUM_VOICES - 1);

    t_state            r_state, n_state;
    logic [VIDX_W-1:0] r_voice, n_voice;
    logic              r_done, n_done;
    logic              accept;

    assign accept = i_start && (r_state == ST_IDLE);

    // state, voice counter and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_voice <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_voice <= n_voice;
            r_done  <= n_done;
        end
    end

    // next state and commands
    always_comb begin
        n_state      = r_state;
        n_voice      = r_voice;
        n_done       = 1'b0;
        o_cmd        = '0;
        o_cmd.load   = accept;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_voice = '0;
                    n_state = (i_action == ACT_TICK) ? ST_SCAN : ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec   = 1'b1;
                o_cmd.finish = 1'b1;
                n_done       = 1'b1;
                n_state      = ST_IDLE;
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (r_voice == LAST_VOICE) begin
                    n_state = ST_FLUSH;
                end else begin
                    n_voice = r_voice + 1'b1;
                end
            end
            ST_FLUSH: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                o_cmd.finish = 1'b1;
                n_done       = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy  = (r_state != ST_IDLE);
    assign o_done  = r_done;
    assign o_voice = r_voice;

endmodule

// ===== rtl/core/wvm_datapath.sv =====
// datapath: voice registers, note tables, wave memory and mix accumulator
module wvm_datapath
    import wvm_pkg::*;
#(
    parameter int NUM_VOICES    = DEF_NUM_VOICES,
    parameter int MAX_TABLE_LEN = DEF_MAX_TABLE_LEN,
    localparam int VIDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic [VIDX_W-1:0] i_voice,
    input  t_in_item          i_item,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_data,
    output t_out_item         o_result
);

    localparam int ELEM_W  = $clog2(MAX_TABLE_LEN);
    localparam int LEN_W   = $clog2(MAX_TABLE_LEN + 1);
    localparam int SUM_W   = ((LEN_W > 8) ? LEN_W : 8) + 1;
    localparam int DEPTH   = NUM_TABLES * MAX_TABLE_LEN;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(NUM_VOICES + 1);
    localparam int ACC_W   = 22 + VIDX_W;
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(524287);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-524288);

    // latched request and configuration
    t_in_item          r_item;
    logic [15:0]       r_offset;

    // voice state
    logic [NUM_VOICES-1:0] r_on;
    logic [3:0]            r_vtable [NUM_VOICES];
    logic [ELEM_W-1:0]     r_velem  [NUM_VOICES];
    logic [2:0]            r_vstep  [NUM_VOICES];
    logic [15:0]           r_vmeas  [NUM_VOICES];
    logic [7:0]            r_vloc   [NUM_VOICES];
    logic [CNT_W-1:0]      r_count;

    // note lengths and sample store
    logic [LEN_W-1:0]      r_len [NUM_TABLES];
    logic signed [15:0]    mem [DEPTH];
    logic signed [15:0]    r_rd_data;
    logic                  r_add_pend;
    logic signed [ACC_W-1:0] r_acc;
    t_out_item             r_result;

    // combinational signals
    logic [3:0]        len_code;
    logic [LEN_W-1:0]  len_sel;
    logic              free_found;
    logic [VIDX_W-1:0] free_idx;
    logic              step_bad;
    logic              start_ok;
    logic              write_ok;
    logic              length_ok;
    logic              v_on;
    logic              v_end;
    logic              v_play;
    logic [SUM_W-1:0]  e_sum, e_wrap1, e_wrap2, len_ext;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic [CNT_W-1:0]  count_after;
    t_status           stat;
    logic [2:0]        vidx_out;
    logic signed [19:0] mix_out;

    // length lookup, one address shared by scan and start
    always_comb begin
        len_code = i_cmd.scan ? r_vtable[i_voice] : r_item.note_code;
        if (32'(len_code) < NUM_TABLES) begin
            len_sel = r_len[len_code];
        end else begin
            len_sel = LEN_W'(1);
        end
        len_ext = SUM_W'(len_sel);
    end

    // lowest free voice
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int v = NUM_VOICES - 1; v >= 0; v--) begin
            if (!r_on[v]) begin
                free_found = 1'b1;
                free_idx   = VIDX_W'(v);
            end
        end
    end

    // request checks
    always_comb begin
        step_bad  = (SUM_W'(1) << r_item.pitch) > len_ext;
        start_ok  = free_found && !step_bad;
        write_ok  = (32'(r_item.note_code) < NUM_TABLES) &&
                    (32'(r_item.table_address) < MAX_TABLE_LEN);
        length_ok = (32'(r_item.note_code) < NUM_TABLES) &&
                    (r_item.table_length != '0) &&
                    (32'(r_item.table_length) <= MAX_TABLE_LEN);
    end

    // scanned voice: end test and element advance
    always_comb begin
        v_on    = r_on[i_voice];
        v_end   = (r_vmeas[i_voice] <= r_item.cur_measure) &&
                  (r_vloc[i_voice] <= r_item.cur_location);
        v_play  = i_cmd.scan && v_on && !v_end;
        e_sum   = SUM_W'(r_velem[i_voice]) + (SUM_W'(1) << r_vstep[i_voice]);
        e_wrap1 = (e_sum >= len_ext) ? (e_sum - len_ext) : e_sum;
        e_wrap2 = (e_wrap1 >= len_ext) ? '0 : e_wrap1;
        rd_addr = ADDR_W'(r_vtable[i_voice]) * ADDR_W'(MAX_TABLE_LEN) +
                  ADDR_W'(r_velem[i_voice]);
        wr_addr = ADDR_W'(r_item.note_code) * ADDR_W'(MAX_TABLE_LEN) +
                  ADDR_W'(r_item.table_address);
    end

    // request latch and offset register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= OFFSET_RESET;
        end else if (i_cfg_we) begin
            r_offset <= i_cfg_data;
        end
        if (i_cmd.load) begin
            r_item <= i_item;
        end
    end

    // voice on bits and active count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on    <= '0;
            r_count <= '0;
        end else if (i_cmd.exec && (r_item.action == ACT_START) && start_ok) begin
            r_on[free_idx] <= 1'b1;
            r_count        <= r_count + 1'b1;
        end else if (i_cmd.scan && v_on && v_end) begin
            r_on[i_voice] <= 1'b0;
            r_count       <= r_count - 1'b1;
        end
    end

    // voice parameters
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && (r_item.action == ACT_START) && start_ok) begin
            r_vtable[free_idx] <= r_item.note_code;
            r_velem[free_idx]  <= '0;
            r_vstep[free_idx]  <= r_item.pitch;
            r_vmeas[free_idx]  <= r_item.end_measure;
            r_vloc[free_idx]   <= r_item.end_location;
        end else if (v_play) begin
            r_velem[i_voice] <= ELEM_W'(e_wrap2);
        end
    end

    // note length table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < NUM_TABLES; t++) begin
                r_len[t] <= LEN_W'(1);
            end
        end else if (i_cmd.exec && (r_item.action == ACT_LENGTH) && length_ok) begin
            r_len[r_item.note_code] <= LEN_W'(r_item.table_length);
        end
    end

    // wave memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && (r_item.action == ACT_WRITE) && write_ok) begin
            mem[wr_addr] <= r_item.sample_value;
        end
        r_rd_data <= mem[rd_addr];
    end

    // mix accumulator, adds each registered read in the cycle after it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_add_pend <= 1'b0;
        end else begin
            r_add_pend <= v_play && (32'(r_vtable[i_voice]) < NUM_TABLES);
        end
        if (i_cmd.load) begin
            r_acc <= signed'(ACC_W'(r_offset));
        end else if (r_add_pend) begin
            r_acc <= r_acc + ACC_W'(r_rd_data);
        end
    end

    // result fields
    always_comb begin
        stat        = STAT_OK;
        vidx_out    = '0;
        count_after = r_count;
        mix_out     = '0;
        case (r_item.action)
            ACT_TICK: begin
                if (r_acc > SAT_HI) begin
                    mix_out = 20'sh7FFFF;
                end else if (r_acc < SAT_LO) begin
                    mix_out = 20'sh80000;
                end else begin
                    mix_out = r_acc[19:0];
                end
            end
            ACT_START: begin
                if (!free_found) begin
                    stat = STAT_NO_VOICE;
                end else if (step_bad) begin
                    stat = STAT_STEP;
                end else begin
                    vidx_out    = 3'(free_idx);
                    count_after = r_count + 1'b1;
                end
            end
            ACT_WRITE: begin
                if (!write_ok) begin
                    stat = STAT_BAD_ADDR;
                end
            end
            ACT_LENGTH: begin
                if (!length_ok) begin
                    stat = STAT_BAD_ADDR;
                end
            end
            default: begin
                stat = STAT_OK;
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_result.mixed_sample  <= mix_out;
            r_result.status        <= stat;
            r_result.voice_index   <= vidx_out;
            r_result.active_voices <= (32'(count_after) > 15) ? 4'd15 : 4'(count_after);
        end
    end

    assign o_result = r_result;

endmodule

// ===== rtl/core/wavetable_voice_mixer.sv =====
// top level of the polyphonic wavetable voice mixer
// A request is taken when i_start is high and o_busy is low. During a tick
// one voice is visited per cycle through the single read port of the wave
// memory, then a flush state waits for the last registered read and a
// finish state saturates the mix. Start, sample write and length write
// requests pass through a single execute state. Each result is shown
// for one cycle with o_done high and must be taken then; o_busy is
// already low in that cycle so the next request may enter. The audio
// offset is written through i_cfg_valid, always ready, and is only to
// be changed while the mixer is idle.
module wavetable_voice_mixer
    import wvm_pkg::*;
#(
    parameter int NUM_VOICES    = DEF_NUM_VOICES,
    parameter int MAX_TABLE_LEN = DEF_MAX_TABLE_LEN
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  t_in_item    i_cmd,
    output logic        o_done,
    output t_out_item   o_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    localparam int VIDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

    t_dp_cmd           dp_cmd;
    logic [VIDX_W-1:0] voice;

    // configuration channel is always free
    assign o_cfg_ready = 1'b1;

    // sequencer
    wvm_ctrl #(
        .NUM_VOICES (NUM_VOICES)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_action (i_cmd.action),
        .o_busy   (o_busy),
        .o_done   (o_done),
        .o_cmd    (dp_cmd),
        .o_voice  (voice)
    );

    // storage and arithmetic
    wvm_datapath #(
        .NUM_VOICES    (NUM_VOICES),
        .MAX_TABLE_LEN (MAX_TABLE_LEN)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .i_voice    (voice),
        .i_item     (i_cmd),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_result   (o_result)
    );

endmodule

// ===== rtl/core/wvm_checker.sv =====
// port-level checks of the voice mixer and their bind to the top level
module wvm_checker
    import wvm_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_start,
    input logic      o_busy,
    input logic      o_done,
    input t_out_item o_result
);

    // an accepted request makes the mixer busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("mixer not busy after accepting a request");

    // results never come in adjacent cycles
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for two cycles");

    // the result cycle already admits the next request
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("mixer busy while showing a result");

    // a failed request reports no voice and no mix
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status != STAT_OK)) |->
            ((o_result.voice_index == 3'd0) && (o_result.mixed_sample == 20'sd0)))
        else $error("failed request carries a voice or mix value");

endmodule

bind wavetable_voice_mixer wvm_checker u_wvm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .o_done   (o_done),
    .o_result (o_result)
);
